// ===== rtl/dsa_pkg.sv =====
`default_nettype none
package dsa_pkg;

    localparam int WORD_BITS = 32;
    localparam int REM_BITS  = 4;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every x below 2^36
    localparam int DIV10_SHIFT = 39;
    localparam logic [35:0] DIV10_RECIP = 36'hCCCCCCCCD;

    typedef struct packed {
        logic lo_is_a;  // operand a carries the smaller scale
        logic stop;     // scaling up has ended for good
        logic dodiv;    // this step divides the larger-scale operand
    } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/dsa_if.sv =====
`default_nettype none
interface dsa_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] a_mant_lo;
    logic [31:0] a_mant_hi;
    logic [4:0]  a_scale;
    logic [63:0] b_mant_lo;
    logic [31:0] b_mant_hi;
    logic [4:0]  b_scale;

    modport source (output valid, a_mant_lo, a_mant_hi, a_scale,
                     b_mant_lo, b_mant_hi, b_scale, input ready);
    modport sink   (input valid, a_mant_lo, a_mant_hi, a_scale,
                     b_mant_lo, b_mant_hi, b_scale, output ready);
endinterface

interface dsa_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] a_out_lo;
    logic [31:0] a_out_hi;
    logic [63:0] b_out_lo;
    logic [31:0] b_out_hi;
    logic [4:0]  common_scale;

    modport source (output valid, a_out_lo, a_out_hi, b_out_lo, b_out_hi,
                     common_scale, input ready);
    modport sink   (input valid, a_out_lo, a_out_hi, b_out_lo, b_out_hi,
                     common_scale, output ready);
endinterface
`default_nettype wire

// ===== rtl/dsa_decide.sv =====
`default_nettype none
module dsa_decide #(
    parameter int MANT_BITS = 96,
    parameter int W         = 96,
    parameter int SW        = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            v_in,
    input  wire logic [W-1:0]    a_in,
    input  wire logic [W-1:0]    b_in,
    input  wire logic [SW-1:0]   ls_in,
    input  wire logic [SW-1:0]   hs_in,
    input  wire dsa_pkg::ctl_t   ctl_in,
    output logic                 v_out,
    output logic [W-1:0]         a_out,
    output logic [W-1:0]         b_out,
    output logic [SW-1:0]        ls_out,
    output logic [SW-1:0]        hs_out,
    output dsa_pkg::ctl_t        ctl_out
);
    import dsa_pkg::*;

    logic          v_reg;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [SW-1:0] ls_reg, ls_next;
    logic [SW-1:0] hs_reg, hs_next;
    ctl_t          ctl_reg, ctl_next;

    logic [W-1:0]  lo;
    logic [W+3:0]  prod;
    logic          guard;
    logic          fits;

    always_comb
    begin
        lo    = ctl_in.lo_is_a ? a_in : b_in;
        // top set bit at MANT_BITS-4 or below
        guard = (lo >> (MANT_BITS - 3)) == '0;
        prod  = {3'b000, lo, 1'b0} + {1'b0, lo, 3'b000};
        fits  = (prod >> MANT_BITS) == '0;

        a_next   = a_in;
        b_next   = b_in;
        ls_next  = ls_in;
        hs_next  = hs_in;
        ctl_next = ctl_in;
        ctl_next.dodiv = 1'b0;

        if (ls_in < hs_in)
        begin
            if (!ctl_in.stop && guard && fits)
            begin
                if (ctl_in.lo_is_a)
                    a_next = prod[W-1:0];
                else
                    b_next = prod[W-1:0];
                ls_next = ls_in + 1'b1;
            end
            else
            begin
                ctl_next.stop  = 1'b1;
                ctl_next.dodiv = 1'b1;
                hs_next = hs_in - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            ls_reg  <= ls_next;
            hs_reg  <= hs_next;
            ctl_reg <= ctl_next;
        end
    end

    assign v_out   = v_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign ls_out  = ls_reg;
    assign hs_out  = hs_reg;
    assign ctl_out = ctl_reg;

endmodule
`default_nettype wire

// ===== rtl/dsa_divw.sv =====
`default_nettype none
module dsa_divw #(
    parameter int W   = 96,
    parameter int SW  = 5,
    parameter int IDX = 2
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     v_in,
    input  wire logic [W-1:0]             a_in,
    input  wire logic [W-1:0]             b_in,
    input  wire logic [SW-1:0]            ls_in,
    input  wire logic [SW-1:0]            hs_in,
    input  wire dsa_pkg::ctl_t            ctl_in,
    input  wire logic [dsa_pkg::REM_BITS-1:0] rem_in,
    output logic                          v_out,
    output logic [W-1:0]                  a_out,
    output logic [W-1:0]                  b_out,
    output logic [SW-1:0]                 ls_out,
    output logic [SW-1:0]                 hs_out,
    output dsa_pkg::ctl_t                 ctl_out,
    output logic [dsa_pkg::REM_BITS-1:0]  rem_out
);
    import dsa_pkg::*;

    logic                 v_reg;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [SW-1:0]        ls_reg;
    logic [SW-1:0]        hs_reg;
    ctl_t                 ctl_reg;
    logic [REM_BITS-1:0]  rem_reg, rem_next;

    logic [W-1:0]                    hi;
    logic [REM_BITS+WORD_BITS-1:0]   cur;
    logic [71:0]                     recip_prod;
    logic [WORD_BITS-1:0]            q;
    logic [REM_BITS+WORD_BITS-1:0]   q10;
    logic [REM_BITS+WORD_BITS-1:0]   r;

    always_comb
    begin
        hi         = ctl_in.lo_is_a ? b_in : a_in;
        cur        = {rem_in, hi[IDX*WORD_BITS +: WORD_BITS]};
        recip_prod = 72'(cur) * 72'(DIV10_RECIP);
        q          = recip_prod[DIV10_SHIFT +: WORD_BITS];
        q10        = {q, 3'b000} + {3'b000, q, 1'b0};
        r          = cur - q10;

        a_next   = a_in;
        b_next   = b_in;
        rem_next = rem_in;
        if (ctl_in.dodiv)
        begin
            hi[IDX*WORD_BITS +: WORD_BITS] = q;
            rem_next = r[REM_BITS-1:0];
            if (ctl_in.lo_is_a)
                b_next = hi;
            else
                a_next = hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            ls_reg  <= ls_in;
            hs_reg  <= hs_in;
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
        end
    end

    assign v_out   = v_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign ls_out  = ls_reg;
    assign hs_out  = hs_reg;
    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;

endmodule
`default_nettype wire

// ===== rtl/decimal_scale_align.sv =====
// Decimal scale alignment: brings two unsigned mantissas, each with a power
// of ten scale, to one common scale. The operand with the smaller scale is
// multiplied by ten while the scales differ and the product still fits; the
// other operand is then divided by ten, truncating, for whatever difference
// remains. The work runs in MAX_SCALE steps, and each step takes NW+1
// pipeline stages (one stage that chooses and applies a multiply by ten, then
// NW stages that divide one 32-bit word each, top word first), where NW is
// MANT_BITS rounded up to whole 32-bit words. A new pair enters on every
// cycle while no result is held at the output, so the sustained rate is one
// transfer per cycle. A stall at the output holds the whole pipeline in place.
`default_nettype none
module decimal_scale_align #(
    parameter int MANT_BITS = 96,
    parameter int MAX_SCALE = 28
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dsa_in_if.sink     in_ch,
    dsa_out_if.source  out_ch
);
    import dsa_pkg::*;

    localparam int NW    = (MANT_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int W     = NW * WORD_BITS;
    localparam int XW    = (W > 96) ? W : 96;
    localparam int SW    = $clog2(MAX_SCALE + 1);
    localparam int PER   = NW + 1;
    localparam int NST   = MAX_SCALE * PER;
    localparam logic [W-1:0] MASK = {W{1'b1}} >> (W - MANT_BITS);

    logic                 v   [NST+1];
    logic [W-1:0]         a   [NST+1];
    logic [W-1:0]         b   [NST+1];
    logic [SW-1:0]        ls  [NST+1];
    logic [SW-1:0]        hs  [NST+1];
    ctl_t                 ctl [NST+1];
    logic [REM_BITS-1:0]  rem [NST+1];

    logic          advance;
    logic [XW-1:0] a_wide, b_wide;
    logic [SW-1:0] as_sat, bs_sat;
    logic [XW-1:0] a_res, b_res;

    // Advance every stage together unless a finished result is held.
    assign advance     = !v[NST] || out_ch.ready;
    assign in_ch.ready = advance;

    // Drop mantissa bits above MANT_BITS and saturate the scales.
    always_comb
    begin
        a_wide = XW'({in_ch.a_mant_hi, in_ch.a_mant_lo});
        b_wide = XW'({in_ch.b_mant_hi, in_ch.b_mant_lo});
        as_sat = (6'(in_ch.a_scale) > 6'(MAX_SCALE)) ? SW'(MAX_SCALE) : SW'(in_ch.a_scale);
        bs_sat = (6'(in_ch.b_scale) > 6'(MAX_SCALE)) ? SW'(MAX_SCALE) : SW'(in_ch.b_scale);

        v[0]   = in_ch.valid;
        a[0]   = a_wide[W-1:0] & MASK;
        b[0]   = b_wide[W-1:0] & MASK;
        ctl[0] = '0;
        rem[0] = '0;
        if (as_sat < bs_sat)
        begin
            ctl[0].lo_is_a = 1'b1;
            ls[0] = as_sat;
            hs[0] = bs_sat;
        end
        else
        begin
            ls[0] = bs_sat;
            hs[0] = as_sat;
        end
    end

    for (genvar k = 0; k < MAX_SCALE; k++)
    begin : g_step
        localparam int S = k * PER;

        dsa_decide #(
            .MANT_BITS (MANT_BITS),
            .W         (W),
            .SW        (SW)
        ) u_decide (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .v_in    (v[S]),
            .a_in    (a[S]),
            .b_in    (b[S]),
            .ls_in   (ls[S]),
            .hs_in   (hs[S]),
            .ctl_in  (ctl[S]),
            .v_out   (v[S+1]),
            .a_out   (a[S+1]),
            .b_out   (b[S+1]),
            .ls_out  (ls[S+1]),
            .hs_out  (hs[S+1]),
            .ctl_out (ctl[S+1])
        );
        // Each division starts with a zero remainder.
        assign rem[S+1] = '0;

        for (genvar j = 0; j < NW; j++)
        begin : g_word
            dsa_divw #(
                .W   (W),
                .SW  (SW),
                .IDX (NW - 1 - j)
            ) u_divw (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .v_in    (v[S+1+j]),
                .a_in    (a[S+1+j]),
                .b_in    (b[S+1+j]),
                .ls_in   (ls[S+1+j]),
                .hs_in   (hs[S+1+j]),
                .ctl_in  (ctl[S+1+j]),
                .rem_in  (rem[S+1+j]),
                .v_out   (v[S+2+j]),
                .a_out   (a[S+2+j]),
                .b_out   (b[S+2+j]),
                .ls_out  (ls[S+2+j]),
                .hs_out  (hs[S+2+j]),
                .ctl_out (ctl[S+2+j]),
                .rem_out (rem[S+2+j])
            );
        end
    end

    assign a_res = XW'(a[NST]);
    assign b_res = XW'(b[NST]);

    assign out_ch.valid        = v[NST];
    assign out_ch.a_out_lo     = a_res[63:0];
    assign out_ch.a_out_hi     = a_res[95:64];
    assign out_ch.b_out_lo     = b_res[63:0];
    assign out_ch.b_out_hi     = b_res[95:64];
    assign out_ch.common_scale = 5'(ls[NST]);

endmodule
`default_nettype wire
